FILE: rtl/sync_length_checksum_deframer_unit_assert.svh
// Assertion macros used by the deframer RTL.
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_UNIT_ASSERT_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define SLCD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("Deframer assertion failed.");
`define SLCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("Deframer assertion failed.");
`else
`define SLCD_ASSERT_IMP(label, clk, rst, ante, cons)
`define SLCD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/slcd_pkg.sv
package slcd_pkg;

  localparam int WORD_W    = 32;
  localparam int INDEX_W   = 30;
  localparam int BYTES_W   = 34;
  localparam int PHASE_W   = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CAPW_W    = 31;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_BYTES = 1'b1;

  typedef enum logic [PHASE_W-1:0] {
    PH_SYNC    = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CHECK   = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  typedef struct packed {
    logic [WORD_W-1:0] sync_word;
    logic [CAPW_W-1:0] cap_words;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] parser_phase;
    logic               store_valid;
    logic [INDEX_W-1:0] store_index;
    logic [WORD_W-1:0]  store_word;
    logic [BYTES_W-1:0] message_bytes;
    logic               checksum_failed;
  } result_t;

endpackage

FILE: rtl/slcd_cfg.sv
module slcd_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [slcd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [slcd_pkg::WORD_W-1:0]         cfg_data,
  output slcd_pkg::cfg_t                      cfg
);
  import slcd_pkg::*;

  logic [WORD_W:0]   cap_sum;
  logic [CAPW_W-1:0] cap_words_next;

  // The store holds ceil(bytes / 4) words, computed without wrap.
  assign cap_sum        = {1'b0, cfg_data} + (WORD_W+1)'(3);
  assign cap_words_next = cap_sum[WORD_W:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_word <= '0;
      cfg.cap_words <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SYNC_WORD:      cfg.sync_word <= cfg_data;
        REG_CAPACITY_BYTES: cfg.cap_words <= cap_words_next;
        default:            ;
      endcase
    end
  end

endmodule

FILE: rtl/slcd_core.sv
module slcd_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [slcd_pkg::WORD_W-1:0] word,
  input  slcd_pkg::cfg_t              cfg,
  output slcd_pkg::result_t           res_next
);
  import slcd_pkg::*;

  phase_t             phase, phase_next;
  logic [WORD_W-1:0]  word_cursor, word_cursor_next;
  logic [WORD_W-1:0]  running_sum, running_sum_next;
  logic [WORD_W-1:0]  frame_length, frame_length_next;
  logic [WORD_W-1:0]  cursor_inc;

  assign cursor_inc = word_cursor + WORD_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SYNC;
      word_cursor  <= '0;
      running_sum  <= '0;
      frame_length <= '0;
    end else if (step) begin
      phase        <= phase_next;
      word_cursor  <= word_cursor_next;
      running_sum  <= running_sum_next;
      frame_length <= frame_length_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    word_cursor_next  = word_cursor;
    running_sum_next  = running_sum;
    frame_length_next = frame_length;
    res_next          = '0;
    case (phase)
      PH_LENGTH: begin
        frame_length_next = word;
        phase_next        = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (word_cursor < {1'b0, cfg.cap_words}) begin
          res_next.store_valid = 1'b1;
          res_next.store_index = word_cursor[INDEX_W-1:0];
          res_next.store_word  = word;
        end
        running_sum_next = running_sum + word;
        word_cursor_next = cursor_inc;
        if (cursor_inc >= frame_length) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (word != running_sum) begin
          res_next.checksum_failed = 1'b1;
          phase_next               = PH_SYNC;
        end else begin
          res_next.message_bytes = {word_cursor, 2'b00};
          phase_next             = PH_DONE;
        end
      end
      default: begin
        if (word == cfg.sync_word) begin
          word_cursor_next = '0;
          running_sum_next = '0;
          phase_next       = PH_LENGTH;
        end else begin
          phase_next = PH_SYNC;
        end
      end
    endcase
    res_next.parser_phase = phase_next;
  end

endmodule

FILE: rtl/sync_length_checksum_deframer_unit.sv
// Channel   Direction  Handshake             Payload
// word      in         word_valid/stall      word_in
// result    out        result_valid/stall    parser_phase .. checksum_failed
// cfg       in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// Each word is captured in an input register, processed, and its result lands
// in an output register, so one word per cycle is sustained while result_stall is low.
// A result is valid once its word has passed the input register and the result register.
// The result register frees the input side: a word is taken into an empty input register while a result waits.
// Reset clears the parser state and the valid flags of both registers; cfg_ready is always high.
`include "sync_length_checksum_deframer_unit_assert.svh"

module sync_length_checksum_deframer_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                word_valid,
  output logic                                word_stall,
  input  logic [slcd_pkg::WORD_W-1:0]         word_in,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [slcd_pkg::PHASE_W-1:0]        parser_phase,
  output logic                                store_valid,
  output logic [slcd_pkg::INDEX_W-1:0]        store_index,
  output logic [slcd_pkg::WORD_W-1:0]         store_word,
  output logic [slcd_pkg::BYTES_W-1:0]        message_bytes,
  output logic                                checksum_failed,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [slcd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [slcd_pkg::WORD_W-1:0]         cfg_data
);
  import slcd_pkg::*;

  cfg_t              cfg;
  result_t           res, res_next;
  logic              in_full;
  logic [WORD_W-1:0] in_word;
  logic              accept;
  logic              advance;

  assign cfg_ready  = 1'b1;
  assign advance    = in_full && (!result_valid || !result_stall);
  assign word_stall = in_full && !advance;
  assign accept     = word_valid && !word_stall;

  slcd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  slcd_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .word     (in_word),
    .cfg      (cfg),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      in_full      <= accept || (in_full && !advance);
      result_valid <= advance || (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_word <= word_in;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  assign parser_phase    = res.parser_phase;
  assign store_valid     = res.store_valid;
  assign store_index     = res.store_index;
  assign store_word      = res.store_word;
  assign message_bytes   = res.message_bytes;
  assign checksum_failed = res.checksum_failed;

  `SLCD_ASSERT_IMP(a_store_in_payload, clk, rst, result_valid && store_valid, parser_phase == PH_PAYLOAD || parser_phase == PH_CHECK)
  `SLCD_ASSERT_IMP(a_fail_to_sync, clk, rst, result_valid && checksum_failed, parser_phase == PH_SYNC && message_bytes == '0 && !store_valid)
  `SLCD_ASSERT_IMP(a_bytes_on_done, clk, rst, result_valid && message_bytes != '0, parser_phase == PH_DONE)
  `SLCD_ASSERT_NEXT(a_held_word_kept, clk, rst, in_full && result_valid && result_stall, in_full && $stable(in_word))

endmodule

FILE: test/sync_length_checksum_deframer_unit_test.sv
module sync_length_checksum_deframer_unit_test;
  import slcd_pkg::*;

  localparam int HOLDOFF_CYCLES = 120;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 115;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic word_valid = 1'b0;
  logic word_stall;
  logic [WORD_W-1:0] word_in = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [PHASE_W-1:0] parser_phase;
  logic store_valid;
  logic [INDEX_W-1:0] store_index;
  logic [WORD_W-1:0] store_word;
  logic [BYTES_W-1:0] message_bytes;
  logic checksum_failed;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SYNC_WORD;
  logic [WORD_W-1:0] cfg_data = '0;

  sync_length_checksum_deframer_unit u_dut (
    .clk(clk),
    .rst(rst),
    .word_valid(word_valid),
    .word_stall(word_stall),
    .word_in(word_in),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .parser_phase(parser_phase),
    .store_valid(store_valid),
    .store_index(store_index),
    .store_word(store_word),
    .message_bytes(message_bytes),
    .checksum_failed(checksum_failed),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the parser and its registers.
  phase_t parse_phase = PH_SYNC;
  logic [WORD_W-1:0] cursor = '0;
  logic [WORD_W-1:0] payload_sum = '0;
  logic [WORD_W-1:0] frame_len = '0;
  logic [WORD_W-1:0] sync_model = '0;
  logic [WORD_W-1:0] capacity_model = '0;

  logic [WORD_W-1:0] pending_words[$];
  result_t expected_results[$];
  result_t oldest;
  int failures = 0;
  int cycles = 0;
  bit word_fire = 1'b0;

  int burst_left = 0;
  int gap_left = 0;
  int holdoff_requests = 0;
  int holdoff_served = 0;
  int holdoff_left = 0;
  int stall_mode = 0;
  int stall_run = 0;

  function automatic result_t deframe_word(input logic [WORD_W-1:0] w);
    result_t r;
    logic [WORD_W:0] cap_words;
    r = '0;
    cap_words = ({1'b0, capacity_model} + 33'd3) >> 2;
    case (parse_phase)
      PH_LENGTH: begin
        frame_len = w;
        parse_phase = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if ({1'b0, cursor} < cap_words) begin
          r.store_valid = 1'b1;
          r.store_index = cursor[INDEX_W-1:0];
          r.store_word = w;
        end
        payload_sum = payload_sum + w;
        cursor = cursor + 1'b1;
        if (cursor >= frame_len) parse_phase = PH_CHECK;
      end
      PH_CHECK: begin
        if (w != payload_sum) begin
          r.checksum_failed = 1'b1;
          parse_phase = PH_SYNC;
        end else begin
          r.message_bytes = {cursor, 2'b00};
          parse_phase = PH_DONE;
        end
      end
      default: begin
        if (w == sync_model) begin
          cursor = '0;
          payload_sum = '0;
          parse_phase = PH_LENGTH;
        end else begin
          parse_phase = PH_SYNC;
        end
      end
    endcase
    r.parser_phase = parse_phase;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result checking and input acceptance.
  always @(posedge clk) begin
    if (rst) begin
      word_fire = 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("Result transaction with no word outstanding, parser_phase %0d",
                 parser_phase);
          failures++;
        end else begin
          oldest = expected_results.pop_front();
          compare_field("parser_phase", oldest.parser_phase, parser_phase);
          compare_field("store_valid", oldest.store_valid, store_valid);
          compare_field("store_index", oldest.store_index, store_index);
          compare_field("store_word", oldest.store_word, store_word);
          compare_field("message_bytes", oldest.message_bytes, message_bytes);
          compare_field("checksum_failed", oldest.checksum_failed, checksum_failed);
        end
      end
      word_fire = word_valid && !word_stall;
      if (word_fire) expected_results.push_back(deframe_word(word_in));
    end
  end

  // Word sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (!word_valid || word_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        word_valid <= 1'b0;
      end else if (pending_words.size() == 0) begin
        word_valid <= 1'b0;
      end else begin
        word_in <= pending_words.pop_front();
        word_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) :
                       $urandom_range(0, 12);
          gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Result receiver: stall modes that change at random intervals, plus
  // requested long hold-offs.
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (holdoff_served != holdoff_requests) begin
        holdoff_served = holdoff_requests;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        result_stall <= 1'b1;
      end else begin
        if (stall_run == 0) begin
          stall_mode = $urandom_range(0, 3);
          stall_run = $urandom_range(10, 80);
        end else begin
          stall_run--;
        end
        case (stall_mode)
          0: result_stall <= 1'b0;
          1: result_stall <= $urandom_range(0, 3) == 0;
          2: result_stall <= $urandom_range(0, 3) != 0;
          default: result_stall <= stall_run[0];
        endcase
      end
    end
  end

  task automatic program_registers(input logic [WORD_W-1:0] sync_value,
                                   input logic [WORD_W-1:0] cap_value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SYNC_WORD;
    cfg_data <= sync_value;
    do @(posedge clk); while (!cfg_ready);
    sync_model = sync_value;
    @(negedge clk);
    cfg_index <= REG_CAPACITY_BYTES;
    cfg_data <= cap_value;
    do @(posedge clk); while (!cfg_ready);
    capacity_model = cap_value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_words.size() != 0 || word_valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] payload_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_frame(input bit corrupt);
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] w;
    int len;
    sum = '0;
    len = $urandom_range(0, 4) == 0 ? $urandom_range(9, 48) : $urandom_range(0, 8);
    pending_words.push_back(sync_model);
    pending_words.push_back(len);
    for (int i = 0; i < (len == 0 ? 1 : len); i++) begin
      w = payload_value();
      sum = sum + w;
      pending_words.push_back(w);
    end
    if (corrupt) begin
      if ($urandom_range(0, 1) == 0) sum = sum ^ (32'h1 << $urandom_range(0, 31));
      else sum = sum + $urandom_range(1, 32'hFFFF_FFFF);
    end
    pending_words.push_back(sum);
  endtask

  task automatic queue_traffic(input int count);
    int target;
    target = pending_words.size() + count;
    while (pending_words.size() < target) begin
      case ($urandom_range(0, 9))
        7: pending_words.push_back($urandom_range(0, 7) == 0 ? sync_model : $urandom);
        8: queue_frame(1'b1);
        9: repeat ($urandom_range(1, 4)) pending_words.push_back($urandom);
        default: queue_frame($urandom_range(0, 7) == 0);
      endcase
    end
  endtask

  initial begin
    logic [WORD_W-1:0] opening[$];
    logic [WORD_W-1:0] closing[$];
    logic [WORD_W-1:0] sync_value;
    logic [WORD_W-1:0] cap_value;
    opening = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0003, 32'h8000_0000,
                32'h8000_0000, 32'h0000_0001, 32'h0000_0002, 32'h1234_5678,
                32'hFFFF_FFFF, 32'h0000_0001, 32'hA5A5_A5A5, 32'hA5A5_A5A5,
                32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0000_0002, 32'h0000_0000};
    closing = '{32'h5A5A_5A5A, 32'h5A5A_5A5A};

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero-length frame, wrapping sum past capacity, bad checksum, noise
    // after completion, then a frame left open across a register change.
    program_registers(32'hFFFF_FFFF, 32'd5);
    foreach (opening[i]) pending_words.push_back(opening[i]);
    wait_drained();
    program_registers(32'h0000_0000, 32'h0000_0000);
    foreach (closing[i]) pending_words.push_back(closing[i]);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p % 3)
        0: sync_value = $urandom;
        1: sync_value = 32'h0000_0000;
        default: sync_value = 32'hFFFF_FFFF;
      endcase
      case (p)
        0: cap_value = $urandom_range(0, 64);
        1: cap_value = 32'hFFFF_FFFF;
        2: cap_value = 32'h0000_0000;
        3: cap_value = $urandom_range(1, 8);
        4: cap_value = 32'hFFFF_FFFC;
        5: cap_value = $urandom;
        6: cap_value = $urandom_range(0, 200);
        default: cap_value = 32'd1;
      endcase
      program_registers(sync_value, cap_value);
      queue_traffic(PHASE_WORDS);
      if (p == 1 || p == 5) holdoff_requests++;
      wait_drained();
    end

    // A frame whose length never runs out keeps the parser in payload.
    pending_words.push_back(sync_model);
    pending_words.push_back(32'hFFFF_FFFF);
    repeat (10) pending_words.push_back(payload_value());
    wait_drained();

    repeat (6) @(posedge clk);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/slcd_pkg.sv
rtl/slcd_cfg.sv
rtl/slcd_core.sv
rtl/sync_length_checksum_deframer_unit.sv
test/sync_length_checksum_deframer_unit_test.sv
